@@ rtl/pdt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdt_pkg: shared types and constants of the path distance tracker
// Holds the point tag codes, the sum width and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package pdt_pkg;

   // Width of the point tag field
   localparam int unsigned TAG_BITS = 2;

   // Width of the path and distance sums
   localparam int unsigned SUM_BITS = 48;

   // Saturation value of both sums
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   // Point tag codes; the reserved code acts as a plain point
   localparam logic [TAG_BITS-1:0] TAG_PLAIN = 2'd0;
   localparam logic [TAG_BITS-1:0] TAG_START = 2'd1;
   localparam logic [TAG_BITS-1:0] TAG_STOP  = 2'd2;

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_DIFF  = 9'b000000010,
      ST_SQX   = 9'b000000100,
      ST_SQY   = 9'b000001000,
      ST_SQA   = 9'b000010000,
      ST_ROOT  = 9'b000100000,
      ST_ACCUM = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/pdt_req_if.sv @@
// ----------------------------------------------------------------------------
// pdt_req_if: point channel of the path distance tracker
// Valid/ready channel that carries one tagged point per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdt_req_if
   import pdt_pkg::*;
#(
   parameter int unsigned COORD_BITS = 24
);

   logic                         valid;
   logic                         ready;
   logic [TAG_BITS-1:0]          req_type;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source (
      output valid, req_type, point_x, point_y,
      input  ready
   );

   modport sink (
      input  valid, req_type, point_x, point_y,
      output ready
   );

endinterface

`default_nettype wire

@@ rtl/pdt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pdt_rsp_if: result channel of the path distance tracker
// Valid/ready channel that carries one path summary per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdt_rsp_if
   import pdt_pkg::*;
#(
   parameter int unsigned COORD_BITS = 24,
   parameter int unsigned COUNT_BITS = 32
);

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] final_x;
   logic signed [COORD_BITS-1:0] final_y;
   logic [SUM_BITS-1:0]          total_distance;
   logic [COORD_BITS:0]          distance_to_start;
   logic [SUM_BITS-1:0]          average_to_start;
   logic [COUNT_BITS-1:0]        points_counted;

   modport source (
      output valid, final_x, final_y, total_distance, distance_to_start,
             average_to_start, points_counted,
      input  ready
   );

   modport sink (
      input  valid, final_x, final_y, total_distance, distance_to_start,
             average_to_start, points_counted,
      output ready
   );

endinterface

`default_nettype wire

@@ rtl/path_distance_tracker_core.sv @@
// ----------------------------------------------------------------------------
// path_distance_tracker_core: path length odometer over a stream of points
// Tracks a path from a start point to a stop point, summing step lengths and
// distances to the start, and reports totals and the mean at the stop point.
// ----------------------------------------------------------------------------
// Points arrive on req_chan and are ignored until a start point, which arms
// tracking. Each tracked point then takes two distance passes, each a
// difference, two squarings on one multiplier, and a floor square root that
// settles one root bit per cycle, COORD_BITS+1 bits in all. A stop point then
// adds the mean: a restoring division, one quotient bit per cycle, 48 bits in
// all, that shares the root's subtractor. req_chan.ready is high only while
// the sequencer is idle. The summary waits in an output register, so the next
// points are taken while rsp_chan is stalled; only the following stop point
// waits for it. Sums saturate at 2^48-1 and the count at
// 2^COUNT_BITS-1.
// ----------------------------------------------------------------------------
`default_nettype none

module path_distance_tracker_core
   import pdt_pkg::*;
#(
   parameter int unsigned COORD_BITS = 24,
   parameter int unsigned COUNT_BITS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pdt_req_if.sink     req_chan,
   pdt_rsp_if.source   rsp_chan
);

   localparam int unsigned RAD_W  = 2 * COORD_BITS + 2;
   localparam int unsigned SUB_W  = (COORD_BITS + 3 > COUNT_BITS + 1) ?
                                    COORD_BITS + 3 : COUNT_BITS + 1;
   localparam int unsigned ITER_W = $clog2(SUM_BITS);

   // Control registers
   state_type                    state_ff, state_in;
   logic                         tracking_ff, tracking_in;
   logic                         pass_ff, pass_in;
   logic                         stop_ff, stop_in;
   logic [ITER_W-1:0]            iter_ff, iter_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Path state
   logic signed [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic signed [COORD_BITS-1:0] last_x_ff, last_x_in;
   logic signed [COORD_BITS-1:0] last_y_ff, last_y_in;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [SUM_BITS-1:0]          path_sum_ff, path_sum_in;
   logic [SUM_BITS-1:0]          odist_sum_ff, odist_sum_in;
   logic [COUNT_BITS-1:0]        tally_ff, tally_in;

   // Datapath registers
   logic [COORD_BITS-1:0]        mag_x_ff, mag_x_in;
   logic [COORD_BITS-1:0]        mag_y_ff, mag_y_in;
   logic [2*COORD_BITS-1:0]      prod_ff, prod_in;
   logic [RAD_W-1:0]             rad_ff, rad_in;
   logic [SUB_W-1:0]             rem_ff, rem_in;
   logic [COORD_BITS:0]          root_ff, root_in;
   logic [COORD_BITS:0]          step_ff, step_in;
   logic [COORD_BITS:0]          odist_ff, odist_in;
   logic [SUM_BITS-1:0]          num_ff, num_in;

   // Result registers
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic [SUM_BITS-1:0]          rsp_total_ff, rsp_total_in;
   logic [COORD_BITS:0]          rsp_dts_ff, rsp_dts_in;
   logic [SUM_BITS-1:0]          rsp_avg_ff, rsp_avg_in;
   logic [COUNT_BITS-1:0]        rsp_count_ff, rsp_count_in;

   // Combinational helpers
   logic                         req_xfer;
   logic                         rsp_free;
   logic signed [COORD_BITS-1:0] base_x, base_y;
   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic [COORD_BITS:0]          abs_x, abs_y;
   logic [COORD_BITS-1:0]        mag_sel;
   logic [SUB_W-1:0]             sub_a, sub_b;
   logic [SUB_W:0]               sub_out;
   logic                         sub_borrow;
   logic [SUM_BITS:0]            path_add, odist_add;
   logic [SUM_BITS-1:0]          path_next, odist_next;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Form coordinate differences against last or start point
   always_comb begin
      base_x = pass_ff ? origin_x_ff : last_x_ff;
      base_y = pass_ff ? origin_y_ff : last_y_ff;
      diff_x = {base_x[COORD_BITS-1], base_x} - {cur_x_ff[COORD_BITS-1], cur_x_ff};
      diff_y = {base_y[COORD_BITS-1], base_y} - {cur_y_ff[COORD_BITS-1], cur_y_ff};
      abs_x  = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : diff_x;
      abs_y  = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : diff_y;
   end

   assign mag_sel = (state_ff == ST_SQX) ? mag_x_ff : mag_y_ff;

   // Drive the shared trial subtractor for root or quotient bits
   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = SUB_W'({rem_ff[COUNT_BITS-1:0], num_ff[SUM_BITS-1]});
         sub_b = SUB_W'(tally_ff);
      end else begin
         sub_a = SUB_W'({rem_ff[COORD_BITS:0], rad_ff[RAD_W-1 -: 2]});
         sub_b = SUB_W'({root_ff[COORD_BITS-1:0], 2'b01});
      end
      sub_out    = {1'b0, sub_a} - {1'b0, sub_b};
      sub_borrow = sub_out[SUB_W];
   end

   // Saturating sum updates
   always_comb begin
      path_add   = {1'b0, path_sum_ff} + (SUM_BITS+1)'(step_ff);
      odist_add  = {1'b0, odist_sum_ff} + (SUM_BITS+1)'(odist_ff);
      path_next  = path_add[SUM_BITS] ? SUM_MAX : path_add[SUM_BITS-1:0];
      odist_next = odist_add[SUM_BITS] ? SUM_MAX : odist_add[SUM_BITS-1:0];
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      tracking_in  = tracking_ff;
      pass_in      = pass_ff;
      stop_in      = stop_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      path_sum_in  = path_sum_ff;
      odist_sum_in = odist_sum_ff;
      tally_in     = tally_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      prod_in      = prod_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      odist_in     = odist_ff;
      num_in       = num_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_total_in = rsp_total_ff;
      rsp_dts_in   = rsp_dts_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_count_in = rsp_count_ff;

      // Drop the result once it is taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (tracking_ff) begin
                  cur_x_in = req_chan.point_x;
                  cur_y_in = req_chan.point_y;
                  stop_in  = (req_chan.req_type == TAG_STOP);
                  pass_in  = 1'b0;
                  state_in = ST_DIFF;
               end else if (req_chan.req_type == TAG_START) begin
                  tracking_in  = 1'b1;
                  origin_x_in  = req_chan.point_x;
                  origin_y_in  = req_chan.point_y;
                  last_x_in    = req_chan.point_x;
                  last_y_in    = req_chan.point_y;
                  path_sum_in  = '0;
                  odist_sum_in = '0;
                  tally_in     = '0;
               end
            end
         end
         ST_DIFF: begin
            mag_x_in = abs_x[COORD_BITS-1:0];
            mag_y_in = abs_y[COORD_BITS-1:0];
            state_in = ST_SQX;
         end
         ST_SQX: begin
            prod_in  = (2*COORD_BITS)'(mag_sel) * (2*COORD_BITS)'(mag_sel);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            prod_in  = (2*COORD_BITS)'(mag_sel) * (2*COORD_BITS)'(mag_sel);
            rad_in   = RAD_W'(prod_ff);
            state_in = ST_SQA;
         end
         ST_SQA: begin
            rad_in   = rad_ff + RAD_W'(prod_ff);
            rem_in   = '0;
            root_in  = '0;
            iter_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // Settle one root bit from the next radicand bit pair
            if (!sub_borrow) begin
               rem_in  = sub_out[SUB_W-1:0];
               root_in = {root_ff[COORD_BITS-1:0], 1'b1};
            end else begin
               rem_in  = sub_a;
               root_in = {root_ff[COORD_BITS-1:0], 1'b0};
            end
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(COORD_BITS)) begin
               if (pass_ff) begin
                  odist_in = root_in;
                  state_in = ST_ACCUM;
               end else begin
                  step_in  = root_in;
                  pass_in  = 1'b1;
                  state_in = ST_DIFF;
               end
            end
         end
         ST_ACCUM: begin
            path_sum_in  = path_next;
            odist_sum_in = odist_next;
            if (tally_ff != {COUNT_BITS{1'b1}}) begin
               tally_in = tally_ff + 1'b1;
            end
            last_x_in = cur_x_ff;
            last_y_in = cur_y_ff;
            if (stop_ff) begin
               tracking_in = 1'b0;
               num_in      = odist_next;
               rem_in      = '0;
               iter_in     = '0;
               state_in    = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // Settle one quotient bit, shifting it into the dividend
            rem_in  = sub_borrow ? sub_a : sub_out[SUB_W-1:0];
            num_in  = {num_ff[SUM_BITS-2:0], !sub_borrow};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SUM_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free, then load it
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = cur_x_ff;
               rsp_y_in     = cur_y_ff;
               rsp_total_in = path_sum_ff;
               rsp_dts_in   = odist_ff;
               rsp_avg_in   = num_ff;
               rsp_count_in = tally_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tracking_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tracking_ff  <= tracking_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      pass_ff      <= pass_in;
      stop_ff      <= stop_in;
      iter_ff      <= iter_in;
      origin_x_ff  <= origin_x_in;
      origin_y_ff  <= origin_y_in;
      last_x_ff    <= last_x_in;
      last_y_ff    <= last_y_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      path_sum_ff  <= path_sum_in;
      odist_sum_ff <= odist_sum_in;
      tally_ff     <= tally_in;
      mag_x_ff     <= mag_x_in;
      mag_y_ff     <= mag_y_in;
      prod_ff      <= prod_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      step_ff      <= step_in;
      odist_ff     <= odist_in;
      num_ff       <= num_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_total_ff <= rsp_total_in;
      rsp_dts_ff   <= rsp_dts_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Drive the result channel
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.final_x           = rsp_x_ff;
   assign rsp_chan.final_y           = rsp_y_ff;
   assign rsp_chan.total_distance    = rsp_total_ff;
   assign rsp_chan.distance_to_start = rsp_dts_ff;
   assign rsp_chan.average_to_start  = rsp_avg_ff;
   assign rsp_chan.points_counted    = rsp_count_ff;

endmodule

`default_nettype wire

@@ tb/path_distance_tracker_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_distance_tracker_core_tb: self-checking bench of the path odometer
// Walks a short table of hand-picked points, then random start/stop paths
// with stray and broken sequences mixed in. A path predictor follows every
// accepted point and queues the summary that each tracked stop point must return.
// Both handshakes idle at random, and the result side holds off once for a
// long stretch so that the core stalls its point channel.
// ----------------------------------------------------------------------------

module path_distance_tracker_core_tb;
   import pdt_pkg::*;

   localparam int unsigned COORD_BITS = 24;
   localparam int unsigned COUNT_BITS = 32;
   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

   // Reserved tag code, handled by the core as a plain point
   localparam logic [TAG_BITS-1:0] TAG_RESERVED = 2'd3;

   localparam int RANDOM_ITEMS = 1400;
   localparam int PRESSURE_AT  = 40;
   localparam int HOLD_OFF     = 3000;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      logic signed [COORD_BITS-1:0] final_x;
      logic signed [COORD_BITS-1:0] final_y;
      logic [SUM_BITS-1:0]          total_distance;
      logic [COORD_BITS:0]          distance_to_start;
      logic [SUM_BITS-1:0]          average_to_start;
      logic [COUNT_BITS-1:0]        points_counted;
   } path_summary_type;

   typedef struct {
      logic [TAG_BITS-1:0]          tag;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      bit                           typed;
      path_summary_type             want;
   } point_row_type;

   logic clock;
   logic reset;

   pdt_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   pdt_rsp_if #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) rsp_chan ();

   path_distance_tracker_core #(
      .COORD_BITS(COORD_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Path predictor state
   bit                           on_path;
   logic signed [COORD_BITS-1:0] home_x, home_y, prev_x, prev_y;
   logic [SUM_BITS-1:0]          path_len, home_dist_sum;
   logic [COUNT_BITS-1:0]        tally;

   path_summary_type summary_q[$];
   point_row_type    point_table[$];
   path_summary_type no_summary;
   int               counted_points;
   int               offered;
   int               received;
   int               mismatches;
   int               cycle_count;

   // Floor of the Euclidean distance between two points
   function automatic logic [COORD_BITS:0] point_gap(input longint ax, input longint ay,
                                                     input longint bx, input longint by);
      longint            dx, dy;
      longint unsigned   sq, root, trial;
      int                b;
      dx = ax - bx;
      dy = ay - by;
      sq = dx * dx + dy * dy;
      root = 0;
      for (b = COORD_BITS + 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sq) root = trial;
      end
      return root[COORD_BITS:0];
   endfunction

   function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] acc,
                                                   input logic [COORD_BITS:0] delta);
      longint unsigned t;
      t = 64'(acc) + 64'(delta);
      return (t > 64'(SUM_MAX)) ? SUM_MAX : t[SUM_BITS-1:0];
   endfunction

   // Step near a previous coordinate, with some extremes and wild jumps
   function automatic logic signed [COORD_BITS-1:0] next_coord(
         input logic signed [COORD_BITS-1:0] from, input int spread);
      int v;
      case ($urandom_range(0, 7))
         0: begin
            v = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         end
         1: begin
            v = int'($urandom) >>> (32 - COORD_BITS);
         end
         default: begin
            v = int'(from) + int'($urandom_range(0, 2 * spread)) - spread;
            if (v > COORD_MAX) v = COORD_MAX;
            if (v < COORD_MIN) v = COORD_MIN;
         end
      endcase
      return v[COORD_BITS-1:0];
   endfunction

   // Advance the path state by one point; flag a summary on a tracked stop
   task automatic advance_path(input logic [TAG_BITS-1:0] tag,
                               input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y,
                               output bit emits, output path_summary_type s);
      logic [COORD_BITS:0] reach;
      emits = 1'b0;
      if (!on_path) begin
         // arm on a start point, drop anything else
         if (tag == TAG_START) begin
            on_path = 1'b1;
            home_x = x;
            home_y = y;
            prev_x = x;
            prev_y = y;
            path_len = '0;
            home_dist_sum = '0;
            tally = '0;
            counted_points++;
         end
      end else begin
         counted_points++;
         reach = point_gap(x, y, home_x, home_y);
         path_len = sat_sum(path_len, point_gap(prev_x, prev_y, x, y));
         home_dist_sum = sat_sum(home_dist_sum, reach);
         if (tally != {COUNT_BITS{1'b1}}) tally = tally + 1'b1;
         prev_x = x;
         prev_y = y;
         if (tag == TAG_STOP) begin
            on_path = 1'b0;
            emits = 1'b1;
            s.final_x = x;
            s.final_y = y;
            s.total_distance = path_len;
            s.distance_to_start = reach;
            s.average_to_start = (tally != 0) ? home_dist_sum / tally : '0;
            s.points_counted = tally;
         end
      end
   endtask

   // Offer one point after a random gap and hold it until the transfer
   task automatic offer_point(input logic [TAG_BITS-1:0] tag,
                              input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input bit typed, input path_summary_type want);
      int               gap;
      bit               emits;
      path_summary_type s;
      gap = ((offered / 150) % 3 == 2) ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= tag;
      req_chan.point_x  <= x;
      req_chan.point_y  <= y;
      do @(posedge clock); while (!req_chan.ready);
      offered++;
      advance_path(tag, x, y, emits, s);
      if (emits) summary_q.push_back(typed ? want : s);
   endtask

   task automatic add_row(input logic [TAG_BITS-1:0] tag, input int x, input int y);
      point_row_type r;
      r.tag = tag;
      r.x = x[COORD_BITS-1:0];
      r.y = y[COORD_BITS-1:0];
      r.typed = 1'b0;
      r.want = no_summary;
      point_table.push_back(r);
   endtask

   task automatic add_checked_row(input logic [TAG_BITS-1:0] tag, input int x, input int y,
                                  input longint tot, input longint dst, input longint avg,
                                  input longint cnt);
      point_row_type r;
      r.tag = tag;
      r.x = x[COORD_BITS-1:0];
      r.y = y[COORD_BITS-1:0];
      r.typed = 1'b1;
      r.want.final_x = r.x;
      r.want.final_y = r.y;
      r.want.total_distance = tot[SUM_BITS-1:0];
      r.want.distance_to_start = dst[COORD_BITS:0];
      r.want.average_to_start = avg[SUM_BITS-1:0];
      r.want.points_counted = cnt[COUNT_BITS-1:0];
      point_table.push_back(r);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stimulus: directed table, then random paths
   initial begin
      logic signed [COORD_BITS-1:0] px, py;
      logic [TAG_BITS-1:0]          tag;
      int                           r, k, seq_len, spread, base;

      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= TAG_PLAIN;
      req_chan.point_x  <= '0;
      req_chan.point_y  <= '0;
      no_summary.final_x = '0;
      no_summary.final_y = '0;
      no_summary.total_distance = '0;
      no_summary.distance_to_start = '0;
      no_summary.average_to_start = '0;
      no_summary.points_counted = '0;

      // while waiting: plain, stop and reserved points are dropped
      add_row(TAG_PLAIN, 100, 200);
      add_row(TAG_STOP, 300, 400);
      add_row(TAG_RESERVED, -1, -1);
      // full-scale single steps along each axis
      add_row(TAG_START, COORD_MIN, 0);
      add_checked_row(TAG_STOP, COORD_MAX, 0, 16777215, 16777215, 16777215, 1);
      add_row(TAG_START, 0, COORD_MAX);
      add_checked_row(TAG_STOP, 0, COORD_MIN, 16777215, 16777215, 16777215, 1);
      // 3-4-5 triangle and a zero-length path
      add_row(TAG_START, 0, 0);
      add_checked_row(TAG_STOP, 768, 1024, 1280, 1280, 1280, 1);
      add_row(TAG_START, 0, 0);
      add_checked_row(TAG_STOP, 0, 0, 0, 0, 0, 1);
      // start and reserved points while tracking count as plain points
      add_row(TAG_START, 256, 0);
      add_row(TAG_START, 512, 0);
      add_row(TAG_RESERVED, 512, 768);
      add_row(TAG_STOP, COORD_MIN, COORD_MIN);
      // corner to corner hops
      add_row(TAG_START, COORD_MAX, COORD_MAX);
      add_row(TAG_PLAIN, COORD_MIN, COORD_MIN);
      add_row(TAG_PLAIN, COORD_MAX, COORD_MIN);
      add_row(TAG_STOP, -1, 1);
      // out and back
      add_row(TAG_START, 0, 0);
      add_row(TAG_PLAIN, 768, 1024);
      add_checked_row(TAG_STOP, 0, 0, 2560, 0, 640, 2);
      // stop after the path has ended
      add_row(TAG_STOP, 5, 5);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (point_table[i])
         offer_point(point_table[i].tag, point_table[i].x, point_table[i].y,
                     point_table[i].typed, point_table[i].want);

      // random paths: mostly well-formed, some stray points and missing stops
      base = counted_points;
      px = '0;
      py = '0;
      while (counted_points - base < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r == 0) begin
            tag = TAG_BITS'($urandom_range(0, 3));
            offer_point(tag, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0,
                        no_summary);
         end else begin
            spread = 16 << (4 * $urandom_range(0, 3));
            px = COORD_BITS'($urandom);
            py = COORD_BITS'($urandom);
            offer_point(TAG_START, px, py, 1'b0, no_summary);
            seq_len = (r == 1) ? $urandom_range(30, 80) : $urandom_range(0, 10);
            for (k = 0; k < seq_len; k++) begin
               px = next_coord(px, spread);
               py = next_coord(py, spread);
               if ($urandom_range(0, 11) == 0)
                  tag = $urandom_range(0, 1) ? TAG_START : TAG_RESERVED;
               else
                  tag = TAG_PLAIN;
               offer_point(tag, px, py, 1'b0, no_summary);
            end
            if (r != 2)
               offer_point(TAG_STOP, next_coord(px, spread), next_coord(py, spread),
                           1'b0, no_summary);
         end
      end
      req_chan.valid <= 1'b0;

      // drain outstanding summaries, then give the core time to misbehave
      while (summary_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("path_distance_tracker_core_tb: done, clean");
      else
         $display("path_distance_tracker_core_tb: done, errors");
      $finish;
   end

   // Result side: random stalls, one long hold-off, compare each transfer
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (received == PRESSURE_AT)
            stall = HOLD_OFF;
         else
            stall = ((received / 20) % 3 == 2) ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         received++;
         if (summary_q.size() == 0) begin
            $error("summary transfer with no summary expected");
            mismatches++;
         end else begin
            path_summary_type want;
            want = summary_q.pop_front();
            check_field("final_x", want.final_x, rsp_chan.final_x);
            check_field("final_y", want.final_y, rsp_chan.final_y);
            check_field("total_distance", want.total_distance, rsp_chan.total_distance);
            check_field("distance_to_start", want.distance_to_start,
                        rsp_chan.distance_to_start);
            check_field("average_to_start", want.average_to_start,
                        rsp_chan.average_to_start);
            check_field("points_counted", want.points_counted, rsp_chan.points_counted);
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("path_distance_tracker_core_tb: done, errors");
      $finish;
   end

endmodule
